### rtl/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_SEMAPHORES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int PID_BITS_DEF       = 8;

  // Fixed field widths
  localparam int FUNC_W  = 3;
  localparam int SEMID_W = 6;
  localparam int COUNT_W = 15;
  localparam int PIDF_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POST  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WAIT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Depth of the command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SEMID_W-1:0] sem_id;
    logic [COUNT_W-1:0] start_count;
    logic [PIDF_W-1:0]  caller_pid;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] read_value;
    logic               caller_blocks;
    logic               wake_valid;
    logic [PIDF_W-1:0]  wake_pid;
    logic               last;
  } rsp_t;

  // Request class decided by the front end
  typedef enum logic [2:0] {
    K_BAD   = 3'd0,
    K_OPEN  = 3'd1,
    K_CLOSE = 3'd2,
    K_POST  = 3'd3,
    K_WAIT  = 3'd4,
    K_READ  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SEMID_W-1:0] sem_id;
    logic [COUNT_W-1:0] init;
    logic [PIDF_W-1:0]  pid;
  } cmd_t;

endpackage

### rtl/cst_front.sv
`timescale 1ns / 1ps

module cst_front #(
  parameter int NUM_SEMAPHORES = cst_pkg::NUM_SEMAPHORES_DEF
) (
  input  logic          req_valid,
  output logic          req_ready,
  input  cst_pkg::req_t req,
  output logic          push,
  output cst_pkg::cmd_t cmd,
  input  logic          q_full
);
  import cst_pkg::*;

  localparam logic [SEMID_W:0] ID_LIMIT = (SEMID_W+1)'(NUM_SEMAPHORES);

  logic id_bad;

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;
  assign id_bad    = {1'b0, req.sem_id} >= ID_LIMIT;

  // Classify: out-of-range ids and unknown codes collapse to one bad class
  always_comb begin
    cmd.sem_id = req.sem_id;
    cmd.init   = req.start_count;
    cmd.pid    = req.caller_pid;
    case (req.func)
      FUNC_OPEN:  cmd.kind = K_OPEN;
      FUNC_CLOSE: cmd.kind = K_CLOSE;
      FUNC_POST:  cmd.kind = K_POST;
      FUNC_WAIT:  cmd.kind = K_WAIT;
      FUNC_READ:  cmd.kind = K_READ;
      default:    cmd.kind = K_BAD;
    endcase
    if (id_bad) begin
      cmd.kind = K_BAD;
    end
  end

endmodule

### rtl/cst_cmd_queue.sv
`timescale 1ns / 1ps

module cst_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cst_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output cst_pkg::cmd_t pop_cmd
);
  import cst_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] used;
  logic             do_push;
  logic             do_pop;

  assign full      = used == CNT_W'(CMDQ_DEPTH);
  assign pop_valid = used != '0;
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        used <= used + 1'b1;
      end else if (do_pop && !do_push) begin
        used <= used - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/cst_back.sv
`timescale 1ns / 1ps

module cst_back #(
  parameter int NUM_SEMAPHORES = cst_pkg::NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = cst_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS       = cst_pkg::PID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cst_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cst_pkg::rsp_t rsp
);
  import cst_pkg::*;

  localparam int ID_W    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RING_N  = NUM_SEMAPHORES * QUEUE_DEPTH;
  localparam int RING_AW = $clog2(RING_N);
  localparam int RING_W  = (PID_BITS < PIDF_W) ? PID_BITS : PIDF_W;
  localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [QPTR_W-1:0]  head;
    logic [QPTR_W-1:0]  tail;
    logic [FILL_W-1:0]  fill;
  } meta_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WAKE = 3'b100
  } state_t;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_LAST) ? '0 : p + 1'b1;
  endfunction

  state_t                    state;
  state_t                    state_next;
  cmd_t                      cur;
  logic [ID_W-1:0]           cur_id;
  logic [RING_AW-1:0]        base;
  logic [NUM_SEMAPHORES-1:0] open_flags;
  logic                      cur_open;
  logic                      open_set;
  logic                      open_clr;

  meta_t                     meta_mem [NUM_SEMAPHORES];
  meta_t                     meta_q;
  logic                      meta_rd_en;
  logic                      meta_wr_en;
  meta_t                     meta_wr_data;

  logic [RING_W-1:0]         ring_mem [RING_N];
  logic [RING_W-1:0]         ring_q;
  logic                      ring_rd_en;
  logic [RING_AW-1:0]        ring_rd_addr;
  logic                      ring_wr_en;
  logic [RING_AW-1:0]        ring_wr_addr;

  logic [QPTR_W-1:0]         walk_head;
  logic [FILL_W-1:0]         walk_fill;
  logic                      walk_close;
  logic                      walk_en;
  logic [QPTR_W-1:0]         walk_head_next;
  logic [FILL_W-1:0]         walk_fill_next;

  logic                      out_free;
  logic                      emit;
  rsp_t                      res;

  assign cur_id   = cur.sem_id[ID_W-1:0];
  assign base     = RING_AW'(cur_id) * RING_AW'(QUEUE_DEPTH);
  assign cur_open = open_flags[cur_id];
  assign out_free = !rsp_valid || rsp_ready;

  // Sequencer: fetch entry, execute, then drain waiters one word at a time
  always_comb begin
    state_next     = state;
    cmd_ready      = 1'b0;
    meta_rd_en     = 1'b0;
    meta_wr_en     = 1'b0;
    meta_wr_data   = meta_q;
    ring_rd_en     = 1'b0;
    ring_rd_addr   = base + RING_AW'(meta_q.head);
    ring_wr_en     = 1'b0;
    ring_wr_addr   = base + RING_AW'(meta_q.tail);
    open_set       = 1'b0;
    open_clr       = 1'b0;
    walk_en        = 1'b0;
    walk_head_next = meta_q.head;
    walk_fill_next = meta_q.fill;
    emit           = 1'b0;
    res            = '0;
    res.status     = ST_OK;
    res.last       = 1'b1;

    case (state)
      S_IDLE: begin
        cmd_ready  = 1'b1;
        meta_rd_en = cmd_valid;
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cur.kind == K_BAD) begin
          res.status = ST_BAD;
          emit       = out_free;
        end else if (cur.kind == K_OPEN) begin
          res.read_value = COUNT_W'(cur.sem_id);
          emit           = out_free;
          if (!cur_open) begin
            open_set     = out_free;
            meta_wr_en   = out_free;
            meta_wr_data = '{count: cur.init, head: '0, tail: '0, fill: '0};
          end
        end else if (!cur_open) begin
          res.status = ST_BAD;
          emit       = out_free;
        end else begin
          case (cur.kind)
            K_READ: begin
              res.read_value = meta_q.count;
              emit           = out_free;
            end
            K_WAIT: begin
              emit = out_free;
              if (meta_q.count != '0) begin
                meta_wr_en         = out_free;
                meta_wr_data.count = meta_q.count - 1'b1;
              end else if (meta_q.fill == FILL_FULL) begin
                res.status = ST_FULL;
              end else begin
                res.caller_blocks = 1'b1;
                ring_wr_en        = out_free;
                meta_wr_en        = out_free;
                meta_wr_data.tail = ptr_inc(meta_q.tail);
                meta_wr_data.fill = meta_q.fill + 1'b1;
              end
            end
            K_POST, K_CLOSE: begin
              if (meta_q.fill != '0) begin
                // first waiter: fetch its id from the ring
                ring_rd_en = 1'b1;
                walk_en    = 1'b1;
              end else if (cur.kind == K_POST) begin
                emit               = out_free;
                meta_wr_en         = out_free;
                meta_wr_data.count = (meta_q.count == COUNT_MAX) ?
                                     meta_q.count : meta_q.count + 1'b1;
              end else begin
                emit     = out_free;
                open_clr = out_free;
              end
            end
            default: begin
              res.status = ST_BAD;
              emit       = out_free;
            end
          endcase
        end
        if (emit || walk_en) begin
          state_next = walk_en ? S_WAKE : S_IDLE;
        end
      end

      S_WAKE: begin
        res.wake_valid = 1'b1;
        res.wake_pid   = PIDF_W'(ring_q);
        res.last       = !walk_close || (walk_fill == FILL_ONE);
        emit           = out_free;
        walk_head_next = ptr_inc(walk_head);
        walk_fill_next = walk_fill - 1'b1;
        ring_rd_addr   = base + RING_AW'(walk_head_next);
        if (out_free) begin
          if (!walk_close) begin
            meta_wr_en        = 1'b1;
            meta_wr_data.head = walk_head_next;
            meta_wr_data.fill = walk_fill_next;
            state_next        = S_IDLE;
          end else if (walk_fill == FILL_ONE) begin
            open_clr   = 1'b1;
            state_next = S_IDLE;
          end else begin
            ring_rd_en = 1'b1;
            walk_en    = 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_flags <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (open_set) begin
        open_flags[cur_id] <= 1'b1;
      end else if (open_clr) begin
        open_flags[cur_id] <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cur <= cmd;
    end
    if (emit) begin
      rsp <= res;
    end
    if (walk_en) begin
      walk_head  <= walk_head_next;
      walk_fill  <= walk_fill_next;
      walk_close <= cur.kind == K_CLOSE;
    end
  end

  // Semaphore entry memory
  always_ff @(posedge clk) begin
    if (meta_wr_en) begin
      meta_mem[cur_id] <= meta_wr_data;
    end
    if (meta_rd_en) begin
      meta_q <= meta_mem[cmd.sem_id[ID_W-1:0]];
    end
  end

  // Waiter ring memory
  always_ff @(posedge clk) begin
    if (ring_wr_en) begin
      ring_mem[ring_wr_addr] <= cur.pid[RING_W-1:0];
    end
    if (ring_rd_en) begin
      ring_q <= ring_mem[ring_rd_addr];
    end
  end

endmodule

### rtl/counting_semaphore_table.sv
`timescale 1ns / 1ps

// Table of counting semaphores, each with an open flag, a saturating 15-bit
// count and a FIFO ring of waiting process ids. Requests (open, close, post,
// wait, read value) enter through a classifier and a two-word command queue;
// the execution side handles one request at a time. A request is handled as
// an entry memory read, then execute and write back; a post that wakes a
// waiter also reads the ring memory after the entry. A close with N waiters
// gives N result words, one per cycle after the first ring read while the
// output is taken. Each result word carries last on the final word of its
// request. The waiter ring has no reset; only entries written by a wait are
// ever read back.
module counting_semaphore_table #(
  parameter int NUM_SEMAPHORES = cst_pkg::NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = cst_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS       = cst_pkg::PID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cst_pkg::rsp_t rsp
);
  import cst_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  cst_front #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES)
  ) u_front (
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .push     (push),
    .cmd      (push_cmd),
    .q_full   (q_full)
  );

  cst_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_cmd)
  );

  cst_back #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PID_BITS      (PID_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd_ready(q_pop),
    .cmd      (q_cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

### rtl/cst_checker.sv
`timescale 1ns / 1ps

module cst_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input cst_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cst_pkg::rsp_t rsp
);
  import cst_pkg::*;

  // No result word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid after reset");

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // A wake word is a plain ok word with only the pid set
  a_wake_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake_valid |->
      rsp.status == ST_OK && !rsp.caller_blocks && rsp.read_value == '0)
    else $error("wake word carries other fields");

  // An error ends its request and carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      (rsp.status == ST_BAD || rsp.status == ST_FULL) && rsp.last &&
      !rsp.wake_valid && !rsp.caller_blocks && rsp.read_value == '0 &&
      rsp.wake_pid == '0)
    else $error("malformed error word");

  // A non-wake word carries a zero wake_pid
  a_pid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.wake_valid |-> rsp.wake_pid == '0)
    else $error("wake_pid set without wake_valid");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (.*);

### sim/tb_counting_semaphore_table.sv
`timescale 1ns / 1ps

module tb_counting_semaphore_table;
  import cst_pkg::*;

  localparam int NUM_SEMS       = NUM_SEMAPHORES_DEF;
  localparam int QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int HOLDOFF_CYCLES = 220;
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int PHASE_ITEMS    = 160;
  localparam int FUNC_CODES     = 1 << FUNC_W;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  // Traffic shaping
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 49;
  logic        holdoff_go    = 1'b0;
  logic        rsp_hold      = 1'b0;
  logic        req_took      = 1'b0;

  // Request words waiting to go out, result words waiting to come back
  req_t req_backlog[$];
  rsp_t expected_words[$];
  int unsigned reqs_pushed   = 0;
  int unsigned reqs_accepted = 0;

  // Our own copy of the semaphore table
  logic                 copy_open [NUM_SEMS];
  logic [COUNT_W-1:0]   sem_count [NUM_SEMS];
  logic [3:0]           sem_head  [NUM_SEMS];
  logic [3:0]           sem_tail  [NUM_SEMS];
  logic [4:0]           sem_fill  [NUM_SEMS];
  logic [PIDF_W-1:0]    waiter_copy [NUM_SEMS*QDEPTH];

  // Tallies for the summary
  int unsigned words_checked = 0;
  int unsigned wake_count    = 0;
  int unsigned full_count    = 0;
  int unsigned reject_count  = 0;
  int unsigned sat_count     = 0;
  int unsigned block_count   = 0;
  int unsigned error_count   = 0;

  counting_semaphore_table #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES_DEF),
    .QUEUE_DEPTH   (QUEUE_DEPTH_DEF),
    .PID_BITS      (PID_BITS_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t word %0d: %s", $time, words_checked, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic void expect_word(logic [STAT_W-1:0] status, int unsigned value,
                                      logic blocks, logic wvalid,
                                      logic [PIDF_W-1:0] wpid, logic last);
    rsp_t w;
    w.status        = status;
    w.read_value    = value[COUNT_W-1:0];
    w.caller_blocks = blocks;
    w.wake_valid    = wvalid;
    w.wake_pid      = wpid;
    w.last          = last;
    expected_words.push_back(w);
  endfunction

  function automatic logic [PIDF_W-1:0] take_oldest_waiter(int unsigned s);
    logic [PIDF_W-1:0] pid;
    pid         = waiter_copy[s*QDEPTH + sem_head[s]];
    sem_head[s] = sem_head[s] + 1'b1;
    sem_fill[s] = sem_fill[s] - 1'b1;
    return pid;
  endfunction

  // Apply one accepted request to the table copy and queue its result words
  function automatic void apply_request(req_t r);
    int unsigned s;
    logic [PIDF_W-1:0] pid;
    s = 32'(r.sem_id);
    if (r.sem_id >= NUM_SEMS || r.func > FUNC_READ) begin
      reject_count++;
      expect_word(ST_BAD, 0, 1'b0, 1'b0, '0, 1'b1);
    end else if (r.func == FUNC_OPEN) begin
      // open on an already open semaphore keeps its count and waiters
      if (!copy_open[s]) begin
        copy_open[s] = 1'b1;
        sem_count[s] = r.start_count;
        sem_head[s]  = '0;
        sem_tail[s]  = '0;
        sem_fill[s]  = '0;
      end
      expect_word(ST_OK, s, 1'b0, 1'b0, '0, 1'b1);
    end else if (!copy_open[s]) begin
      reject_count++;
      expect_word(ST_BAD, 0, 1'b0, 1'b0, '0, 1'b1);
    end else begin
      case (r.func)
        FUNC_CLOSE: begin
          if (sem_fill[s] == 0) begin
            expect_word(ST_OK, 0, 1'b0, 1'b0, '0, 1'b1);
          end
          while (sem_fill[s] != 0) begin
            pid = take_oldest_waiter(s);
            wake_count++;
            expect_word(ST_OK, 0, 1'b0, 1'b1, pid, sem_fill[s] == 0);
          end
          sem_head[s]  = '0;
          sem_tail[s]  = '0;
          copy_open[s] = 1'b0;
        end
        FUNC_POST: begin
          if (sem_fill[s] != 0) begin
            pid = take_oldest_waiter(s);
            wake_count++;
            expect_word(ST_OK, 0, 1'b0, 1'b1, pid, 1'b1);
          end else begin
            if (sem_count[s] != COUNT_MAX) sem_count[s] = sem_count[s] + 1'b1;
            else sat_count++;
            expect_word(ST_OK, 0, 1'b0, 1'b0, '0, 1'b1);
          end
        end
        FUNC_WAIT: begin
          if (sem_count[s] != 0) begin
            sem_count[s] = sem_count[s] - 1'b1;
            expect_word(ST_OK, 0, 1'b0, 1'b0, '0, 1'b1);
          end else if (sem_fill[s] >= QDEPTH) begin
            full_count++;
            expect_word(ST_FULL, 0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            waiter_copy[s*QDEPTH + sem_tail[s]] = r.caller_pid;
            sem_tail[s] = sem_tail[s] + 1'b1;
            sem_fill[s] = sem_fill[s] + 1'b1;
            block_count++;
            expect_word(ST_OK, 0, 1'b1, 1'b0, '0, 1'b1);
          end
        end
        default: begin
          expect_word(ST_OK, 32'(sem_count[s]), 1'b0, 1'b0, '0, 1'b1);
        end
      endcase
    end
  endfunction

  // Request driver: holds valid and the word until taken
  always @(negedge clk) begin : feed_requests
    logic send;
    req_t next_word;
    send      = req_valid && !req_took;
    next_word = req;
    if (!rst && !send && req_backlog.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      next_word = req_backlog.pop_front();
      send      = 1'b1;
    end
    req_valid <= send;
    req       <= next_word;
  end

  // Result side backpressure
  always @(negedge clk) begin
    rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall while the sender keeps offering
  initial begin : receiver_holdoff
    wait (holdoff_go);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Handshake monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin : watch_ports
    rsp_t want;
    req_took <= req_valid && req_ready;
    if (!rst) begin
      if (req_valid && req_ready) begin
        apply_request(req);
        reqs_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("read_value", 32'(rsp.read_value), 32'(want.read_value));
          check_field("caller_blocks", 32'(rsp.caller_blocks),
                      32'(want.caller_blocks));
          check_field("wake_valid", 32'(rsp.wake_valid), 32'(want.wake_valid));
          check_field("wake_pid", 32'(rsp.wake_pid), 32'(want.wake_pid));
          check_field("last", 32'(rsp.last), 32'(want.last));
        end
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_req(input logic [FUNC_W-1:0] f, input int unsigned id,
                          input int unsigned init, input int unsigned pid);
    req_t r;
    r.func        = f;
    r.sem_id      = id[SEMID_W-1:0];
    r.start_count = init[COUNT_W-1:0];
    r.caller_pid  = pid[PIDF_W-1:0];
    req_backlog.push_back(r);
    reqs_pushed++;
  endtask

  function automatic int unsigned pick_sem();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(3);
    if (roll < 80) return NUM_SEMS - 1;
    return $urandom_range(NUM_SEMS - 1);
  endfunction

  function automatic int unsigned pick_init();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(3);
    if (roll < 70) return COUNT_MAX - $urandom_range(1);
    return $urandom_range(COUNT_MAX);
  endfunction

  // One sequence: mostly well-formed open/use/close runs, some noise
  task automatic random_session();
    int unsigned roll, id, n, k;
    logic [FUNC_W-1:0] f;
    roll = $urandom_range(99);
    id   = pick_sem();
    if (roll < 12) begin
      // noise: any field value, including bad ids and unused codes
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        push_req(FUNC_W'($urandom_range(FUNC_CODES - 1)),
                 $urandom_range((1 << SEMID_W) - 1),
                 $urandom_range(COUNT_MAX), $urandom_range((1 << PIDF_W) - 1));
      end
    end else if (roll < 35) begin
      // pile up waiters, sometimes past a full ring, then drain
      push_req(FUNC_OPEN, id, 0, 0);
      n = ($urandom_range(1) != 0) ? $urandom_range(QDEPTH + 1, QDEPTH + 2)
                                   : $urandom_range(1, QDEPTH);
      for (k = 0; k < n; k++) begin
        push_req(FUNC_WAIT, id, $urandom_range(COUNT_MAX), $urandom_range(255));
      end
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) push_req(FUNC_POST, id, 0, 0);
      if ($urandom_range(99) < 70) push_req(FUNC_CLOSE, id, 0, 0);
    end else begin
      // ordinary use of one semaphore, open skipped now and then
      if ($urandom_range(99) < 92) push_req(FUNC_OPEN, id, pick_init(), 0);
      n = $urandom_range(3, 10);
      for (k = 0; k < n; k++) begin
        roll = $urandom_range(99);
        if (roll < 40) f = FUNC_WAIT;
        else if (roll < 75) f = FUNC_POST;
        else if (roll < 92) f = FUNC_READ;
        else f = FUNC_OPEN;
        push_req(f, id, pick_init(), $urandom_range(255));
      end
      if ($urandom_range(99) < 35) push_req(FUNC_CLOSE, id, 0, 0);
    end
  endtask

  // Sender pause: nothing more goes out until every result word is back
  task automatic wait_quiet();
    while (reqs_accepted != reqs_pushed || expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic with_holdoff);
    int unsigned target;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_holdoff) holdoff_go = 1'b1;
    target = reqs_pushed + PHASE_ITEMS;
    while (reqs_pushed < target) random_session();
    wait_quiet();
  endtask

  initial begin : stimulus
    int f, cycles;
    for (int s = 0; s < NUM_SEMS; s++) begin
      copy_open[s] = 1'b0;
      sem_count[s] = '0;
      sem_head[s]  = '0;
      sem_tail[s]  = '0;
      sem_fill[s]  = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rejects, open twice, saturation, FIFO wake order, empty close
    push_req(FUNC_READ, 0, 0, 0);
    push_req(FUNC_OPEN, NUM_SEMS, 1, 0);
    push_req(FUNC_WAIT, (1 << SEMID_W) - 1, COUNT_MAX, 8'hFF);
    for (f = FUNC_READ + 1; f < FUNC_CODES; f++) push_req(FUNC_W'(f), 0, 0, 0);
    push_req(FUNC_OPEN, 0, 0, 0);
    push_req(FUNC_OPEN, NUM_SEMS - 1, COUNT_MAX, 0);
    push_req(FUNC_OPEN, 0, 123, 0);
    push_req(FUNC_READ, 0, 0, 0);
    push_req(FUNC_POST, NUM_SEMS - 1, 0, 0);
    push_req(FUNC_READ, NUM_SEMS - 1, 0, 0);
    push_req(FUNC_WAIT, NUM_SEMS - 1, 0, 8'h00);
    push_req(FUNC_WAIT, 0, 0, 8'hFF);
    push_req(FUNC_WAIT, 0, 0, 8'h00);
    push_req(FUNC_WAIT, 0, 0, 8'h5A);
    push_req(FUNC_POST, 0, 0, 0);
    push_req(FUNC_CLOSE, 0, 0, 0);
    push_req(FUNC_CLOSE, 0, 0, 0);
    push_req(FUNC_POST, 0, 0, 0);
    push_req(FUNC_OPEN, 1, 15'h5555, 0);
    push_req(FUNC_CLOSE, 1, 0, 0);
    push_req(FUNC_OPEN, 2, 15'h2AAA, 8'hA5);
    push_req(FUNC_READ, 2, 0, 0);
    wait_quiet();

    // Random phases with changing idle patterns
    run_phase(9, 49, 1'b1);
    run_phase(49, 9, 1'b0);
    run_phase(0, 0, 1'b0);

    // Let any stray words show up, then close out
    cycles = 0;
    while (expected_words.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived",
                                expected_words.size()));
    end

    $display("Covered %0d requests and %0d result words: %0d wakes, %0d blocked waits,",
             reqs_accepted, words_checked, wake_count, block_count);
    $display("%0d full-ring refusals, %0d rejected requests, %0d saturated posts.",
             full_count, reject_count, sat_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_cmd_queue.sv
rtl/cst_back.sv
rtl/counting_semaphore_table.sv
rtl/cst_checker.sv
sim/tb_counting_semaphore_table.sv
